// ===== rtl/deq_pkg.sv =====
// deq_pkg: shared types and constants for the double-ended queue
// holds operation and status codes, controller states and the command/status structs
// no dependencies
package deq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    SM_IDLE,
    SM_READ,
    SM_DUMP
  } state_t;

  // output data source
  typedef enum logic {
    OSEL_ZERO,
    OSEL_RDATA
  } osel_t;

  // controller to datapath commands
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    dump_first;
    logic    dump_next;
    logic    out_load;
    osel_t   out_sel;
    status_t out_status;
    logic    out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic is_empty;
    logic is_full;
    logic dump_at_end;
  } stat_t;

endpackage

// ===== rtl/deq_dp.sv =====
// deq_dp: ring buffer datapath with element memory, front/count registers and result register
// depends on deq_pkg; driven by deq_ctrl through cmd_t, reports through stat_t
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  input  deq_pkg::cmd_t                    cmd,
  output deq_pkg::stat_t                   stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [deq_pkg::DATA_W-1:0] out_data,
  output logic [deq_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_last
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_W = (IDX_W+1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // element storage
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r;
  status_t                  out_status_r;
  logic                     out_last_r;

  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] idx_inc;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W:0]   idx_ext_inc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  // ring position of an offset from the front, one compare and subtract
  function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IDX_W-1:0];
  endfunction

  // pointer arithmetic
  assign front_dec   = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign idx_inc     = idx_r + 1'b1;
  assign cnt_m1      = count_r - 1'b1;
  assign idx_ext_inc = {1'b0, idx_r} + 1'b1;

  // status to controller
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.is_empty    = (count_r == '0);
  assign stat.is_full     = (count_r == CNT_W'(DEPTH));
  assign stat.dump_at_end = (idx_ext_inc == (IDX_W+1)'(count_r));

  // memory write and read addressing
  always_comb begin
    wr_en   = cmd.push_front || cmd.push_back;
    wr_addr = cmd.push_front ? front_dec : ring(front_r, count_r[IDX_W-1:0]);
    rd_en   = cmd.pop_front || cmd.pop_back || cmd.dump_first || cmd.dump_next;
    if (cmd.pop_back) begin
      rd_addr = ring(front_r, cnt_m1[IDX_W-1:0]);
    end else if (cmd.dump_next) begin
      rd_addr = ring(front_r, idx_inc);
    end else begin
      rd_addr = front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // front, count and dump index updates
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (cmd.push_front) begin
      front_nxt = front_dec;
    end else if (cmd.pop_front) begin
      front_nxt = ring(front_r, IDX_W'(1));
    end
    if (cmd.push_front || cmd.push_back) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop_front || cmd.pop_back) begin
      count_nxt = cnt_m1;
    end
    if (cmd.dump_first) begin
      idx_nxt = '0;
    end else if (cmd.dump_next) begin
      idx_nxt = idx_inc;
    end
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= (cmd.out_sel == OSEL_RDATA) ? rdata_r : '0;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/deq_ctrl.sv =====
// deq_ctrl: request sequencing state machine for the double-ended queue
// depends on deq_pkg; commands deq_dp through cmd_t and reads its stat_t
module deq_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [deq_pkg::OP_W-1:0]   in_op,
  input  deq_pkg::stat_t             stat,
  output deq_pkg::cmd_t              cmd
);
  import deq_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.out_sel    = OSEL_ZERO;
    cmd.out_status = STS_OK;
    unique case (state_r)
      SM_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          unique case (in_op)
            OP_PUSH_FRONT: begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              if (stat.is_full) begin
                cmd.out_status = STS_FULL;
              end
              cmd.push_front = !stat.is_full;
            end
            OP_PUSH_BACK: begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              if (stat.is_full) begin
                cmd.out_status = STS_FULL;
              end
              cmd.push_back  = !stat.is_full;
            end
            OP_POP_FRONT: begin
              if (stat.is_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STS_EMPTY;
              end else begin
                cmd.pop_front = 1'b1;
                state_nxt     = SM_READ;
              end
            end
            OP_POP_BACK: begin
              if (stat.is_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STS_EMPTY;
              end else begin
                cmd.pop_back = 1'b1;
                state_nxt    = SM_READ;
              end
            end
            OP_DUMP: begin
              if (stat.is_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STS_EMPTY;
              end else begin
                cmd.dump_first = 1'b1;
                state_nxt      = SM_DUMP;
              end
            end
            default: begin
              // undefined codes are dropped without a result
            end
          endcase
        end
      end
      SM_READ: begin
        // popped word is in the read register
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_RDATA;
          cmd.out_last = 1'b1;
          state_nxt    = SM_IDLE;
        end
      end
      SM_DUMP: begin
        // one element per free result slot, next read issued with each load but the last
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_RDATA;
          cmd.out_last = stat.dump_at_end;
          if (stat.dump_at_end) begin
            state_nxt = SM_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = SM_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values kept in a DEPTH-entry ring buffer.
// Each request carries an op (push front, push back, pop front, pop back, dump) and a
// value. Pushes, failed pops and empty dumps are taken directly from idle and give one result;
// a push into a full queue is dropped with status full, a pop or dump of an empty queue
// gives status empty. A successful pop passes through the read state because the element
// memory has a registered read port. A dump streams the elements front to back, one per cycle
// while the result register is free, with last set on the back element; no new request is taken
// until the dump is done. Results sit in an output register; a new request is taken only
// when that register is empty or its result is taken in the same cycle, so a stalled
// result holds off the input. Undefined op codes are consumed with no result.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [deq_pkg::OP_W-1:0]          in_op,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [deq_pkg::DATA_W-1:0] out_data,
  output logic [deq_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_last
);
  import deq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // request sequencer
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring buffer and result register
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (out_last)
  );

`ifndef NO_ASSERTIONS
  // no push is issued into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_back) |-> !stat.is_full)
    else $error("push issued while queue full");

  // no pop or dump read is issued on an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_front || cmd.pop_back || cmd.dump_first) |-> !stat.is_empty)
    else $error("read issued while queue empty");

  // a new request is never taken while a dump is still streaming
  a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !cmd.dump_next)
    else $error("request accepted during dump");

  // a result with a failure status carries zero data and has last set
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_OK) |-> (out_data == '0 && out_last))
    else $error("failure result with data or not last");
`endif

endmodule
